[hw/rtl/trca_pkg.sv]
package trca_pkg;

    // Fixed field widths
    localparam int COL_W       = 6;
    localparam int RULE_W      = 64;
    localparam int NH_W        = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 64;

    // Default ring size
    localparam int RING_WIDTH_DEF = 64;

    // Action codes
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_STEP = 2'd1;
    localparam logic [1:0] ACT_SHOW = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_TOP    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_BOTTOM = 1'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic emit;
        logic step;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic at_last;
    } t_sts;

endpackage

[hw/rtl/two_row_cellular_automaton.sv]
// Load item: written at the accepting edge, the next item may follow at once.
// Step or show item: busy until the last column, one column a cycle through a
// single shared neighbourhood index; column 0 goes via the state and output registers.
// A new item is accepted only when idle again; the receiver cannot stall.
// Reset (synchronous, active low) clears both rows, both rule registers and the controller.
module two_row_cellular_automaton #(
    parameter int RING_WIDTH = trca_pkg::RING_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_action,
    input  logic [trca_pkg::COL_W-1:0]         i_column,
    input  logic                               i_top_cell,
    input  logic                               i_bottom_cell,
    input  logic                               i_cfg_we,
    input  logic [trca_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [trca_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_valid,
    output logic [trca_pkg::COL_W-1:0]         o_out_column,
    output logic                               o_out_top,
    output logic                               o_out_bottom,
    output logic                               o_last
);

    trca_pkg::t_cmd w_cmd;
    trca_pkg::t_sts w_sts;

    trca_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .busy     (busy)
    );

    trca_dp #(
        .RING_WIDTH (RING_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_column      (i_column),
        .i_top_cell    (i_top_cell),
        .i_bottom_cell (i_bottom_cell),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_out_column  (o_out_column),
        .o_out_top     (o_out_top),
        .o_out_bottom  (o_out_bottom),
        .o_last        (o_last)
    );

endmodule

[hw/rtl/trca_ctrl.sv]
module trca_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [1:0]        i_action,
    input  trca_pkg::t_sts    i_sts,
    output trca_pkg::t_cmd    o_cmd,
    output logic              busy
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_STEP = 3'b010,
        ST_SHOW = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (i_action)
                        trca_pkg::ACT_LOAD: o_cmd.load = 1'b1;
                        trca_pkg::ACT_STEP: n_state = ST_STEP;
                        trca_pkg::ACT_SHOW: n_state = ST_SHOW;
                        default: ;
                    endcase
                end
            end
            ST_STEP: begin
                o_cmd.emit = 1'b1;
                o_cmd.step = 1'b1;
                if (i_sts.at_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SHOW: begin
                o_cmd.emit = 1'b1;
                if (i_sts.at_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ST_IDLE);

endmodule

[hw/rtl/trca_dp.sv]
module trca_dp #(
    parameter int RING_WIDTH = trca_pkg::RING_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  trca_pkg::t_cmd                     i_cmd,
    output trca_pkg::t_sts                     o_sts,
    input  logic [trca_pkg::COL_W-1:0]         i_column,
    input  logic                               i_top_cell,
    input  logic                               i_bottom_cell,
    input  logic                               i_cfg_we,
    input  logic [trca_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [trca_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_valid,
    output logic [trca_pkg::COL_W-1:0]         o_out_column,
    output logic                               o_out_top,
    output logic                               o_out_bottom,
    output logic                               o_last
);

    localparam int CW = $clog2(RING_WIDTH);
    localparam logic [CW-1:0] LAST_COL = CW'(RING_WIDTH - 1);

    logic [RING_WIDTH-1:0]          r_top;
    logic [RING_WIDTH-1:0]          r_bot;
    logic [trca_pkg::RULE_W-1:0]    r_rule_top;
    logic [trca_pkg::RULE_W-1:0]    r_rule_bot;
    logic [CW-1:0]                  r_cnt;
    logic                           r_prev_t;
    logic                           r_prev_b;
    logic                           r_first_t;
    logic                           r_first_b;

    logic                           w_at_last;
    logic                           w_at_first;
    logic [CW-1:0]                  w_right_idx;
    logic                           w_left_t;
    logic                           w_left_b;
    logic                           w_ctr_t;
    logic                           w_ctr_b;
    logic                           w_right_t;
    logic                           w_right_b;
    logic [trca_pkg::NH_W-1:0]      w_nh;
    logic                           w_new_t;
    logic                           w_new_b;
    logic                           w_load_ok;

    assign w_at_last   = (r_cnt == LAST_COL);
    assign w_at_first  = (r_cnt == '0);
    assign w_right_idx = w_at_last ? '0 : r_cnt + 1'b1;

    // Columns below the counter already hold the new generation: take the
    // old left cell from the saved copy, and the old column 0 from its copy.
    assign w_left_t  = w_at_first ? r_top[LAST_COL] : r_prev_t;
    assign w_left_b  = w_at_first ? r_bot[LAST_COL] : r_prev_b;
    assign w_ctr_t   = r_top[r_cnt];
    assign w_ctr_b   = r_bot[r_cnt];
    assign w_right_t = w_at_last ? r_first_t : r_top[w_right_idx];
    assign w_right_b = w_at_last ? r_first_b : r_bot[w_right_idx];

    assign w_nh    = {w_right_b, w_ctr_b, w_left_b, w_right_t, w_ctr_t, w_left_t};
    assign w_new_t = r_rule_top[w_nh];
    assign w_new_b = r_rule_bot[w_nh];

    assign w_load_ok = ({1'b0, i_column} < (trca_pkg::COL_W + 1)'(RING_WIDTH));

    assign o_sts.at_last = w_at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top      <= '0;
            r_bot      <= '0;
            r_rule_top <= '0;
            r_rule_bot <= '0;
            r_cnt      <= '0;
            o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    trca_pkg::CFG_RULE_TOP:    r_rule_top <= i_cfg_data;
                    trca_pkg::CFG_RULE_BOTTOM: r_rule_bot <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load && w_load_ok) begin
                r_top[i_column[CW-1:0]] <= i_top_cell;
                r_bot[i_column[CW-1:0]] <= i_bottom_cell;
            end
            if (i_cmd.emit) begin
                r_cnt <= w_at_last ? '0 : r_cnt + 1'b1;
            end
            if (i_cmd.step) begin
                r_top[r_cnt] <= w_new_t;
                r_bot[r_cnt] <= w_new_b;
            end
            o_valid <= i_cmd.emit;
        end
    end

    // Saved old cells and the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_prev_t <= w_ctr_t;
            r_prev_b <= w_ctr_b;
            if (w_at_first) begin
                r_first_t <= w_ctr_t;
                r_first_b <= w_ctr_b;
            end
            o_out_column <= trca_pkg::COL_W'(r_cnt);
            o_out_top    <= i_cmd.step ? w_new_t : w_ctr_t;
            o_out_bottom <= i_cmd.step ? w_new_b : w_ctr_b;
            o_last       <= w_at_last;
        end
    end

endmodule

[hw/rtl/trca_chk.sv]
module trca_chk #(
    parameter int RING_WIDTH = trca_pkg::RING_WIDTH_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [1:0]                  i_action,
    input logic                        o_valid,
    input logic [trca_pkg::COL_W-1:0]  o_out_column,
    input logic                        o_last
);

    // The final column carries the last flag
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_out_column == trca_pkg::COL_W'(RING_WIDTH - 1))
        else $error("last flag on wrong column");

    // Columns come out back to back in ascending order
    a_col_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_valid && !o_last |=>
            o_valid && o_out_column == $past(o_out_column) + 1'b1)
        else $error("column sequence broken");

    // A generation ends after its last column
    a_gen_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_valid && o_last |=> !o_valid)
        else $error("item after last column");

    // An accepted step or show item holds the block busy
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && start && !busy &&
            (i_action == trca_pkg::ACT_STEP || i_action == trca_pkg::ACT_SHOW)
            |=> busy && !o_valid)
        else $error("emit item not taken");

    // A load item never occupies the block
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && start && !busy && i_action == trca_pkg::ACT_LOAD |=> !busy)
        else $error("load made block busy");

endmodule

bind two_row_cellular_automaton trca_chk #(.RING_WIDTH(RING_WIDTH)) u_trca_chk (.*);
